// ===== design/nwom_pkg.sv =====
`default_nettype none

package nwom_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int MODE_W  = 3;
  localparam int WDAY_W  = 3;
  localparam int DAY_W   = 5;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Day count accumulator and the products of the divide-by-100 step.
  localparam int ACC_W  = 15;
  localparam int PROD_W = 27;
  localparam int Q100_W = 7;

  localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);

  // floor(z / 100) == (z * DIV100_MUL) >> DIV100_SHIFT for every 14-bit z.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [MODE_W-1:0] MODE_FIFTH  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LAST   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_TEENTH = 3'd6;

  localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd6;

  // floor(23 * m / 9) for months 1 to 12.
  function automatic logic [4:0] month_term(input logic [MONTH_W-1:0] m);
    logic [4:0] r;
    case (m)
      4'd1:    r = 5'd2;
      4'd2:    r = 5'd5;
      4'd3:    r = 5'd7;
      4'd4:    r = 5'd10;
      4'd5:    r = 5'd12;
      4'd6:    r = 5'd15;
      4'd7:    r = 5'd17;
      4'd8:    r = 5'd20;
      4'd9:    r = 5'd23;
      4'd10:   r = 5'd25;
      4'd11:   r = 5'd28;
      4'd12:   r = 5'd30;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      MONTH_FEB:                  r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
      default:                    r = 5'd31;
    endcase
    return r;
  endfunction

  // Since 8 is 1 modulo 7, the octal digits sum to the same residue.
  function automatic logic [2:0] mod7(input logic [ACC_W-1:0] x);
    logic [5:0] s;
    logic [3:0] s2;
    logic [3:0] r;
    s  = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
    s2 = 4'(s[5:3]) + 4'(s[2:0]);
    r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/nth_weekday_of_month.sv =====
// One item per cycle while the output is not stalled; four register stages with
// valid bits, each stage advancing whenever the next one is empty or moving.
// A stalled output holds each full stage behind it, up to the first empty one.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
`default_nettype none

module nth_weekday_of_month
  import nwom_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // year [13:0], month [17:14], mode [20:18], weekday [23:21]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // meet_day [4:0], zero fill above
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  logic [YEAR_W-1:0]  in_year;
  logic [MONTH_W-1:0] in_month;
  logic [MODE_W-1:0]  in_mode;
  logic [WDAY_W-1:0]  in_wday;

  assign in_year  = s_tdata[13:0];
  assign in_month = s_tdata[17:14];
  assign in_mode  = s_tdata[20:18];
  assign in_wday  = s_tdata[23:21];

  // Stage advance enables, from the output back to the input.
  logic en1, en2, en3, en4;
  logic v1, v2, v3;

  assign en4      = !m_tvalid || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  // Stage 1: validity, year shift for January and February, divide-by-100 product.
  logic               in_ok;
  logic               early;
  logic [YEAR_W-1:0]  in_z;
  logic [ACC_W-1:0]   in_base;

  assign in_ok = (in_year != '0) && (in_year <= YEAR_MAX) &&
                 (in_month >= MONTH_JAN) && (in_month <= MONTH_DEC) &&
                 (in_wday <= WDAY_SAT) && (in_mode <= MODE_TEENTH);
  assign early = in_month < MONTH_MAR;
  assign in_z  = early ? in_year - YEAR_W'(1) : in_year;
  assign in_base = early ?
      ACC_W'(in_year) + ACC_W'(month_term(in_month)) + ACC_W'(5) :
      ACC_W'(in_year) + ACC_W'(month_term(in_month)) + ACC_W'(3);

  logic               ok1;
  logic [MONTH_W-1:0] month1;
  logic [MODE_W-1:0]  mode1;
  logic [WDAY_W-1:0]  wday1;
  logic [YEAR_W-1:0]  z1;
  logic [ACC_W-1:0]   base1;
  logic [PROD_W-1:0]  prod1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
    if (en1) begin
      ok1    <= in_ok;
      month1 <= in_month;
      mode1  <= in_mode;
      wday1  <= in_wday;
      z1     <= in_z;
      base1  <= in_base;
      prod1  <= PROD_W'(in_z) * PROD_W'(DIV100_MUL);
    end
  end

  // Stage 2: century corrections, leap year and month length.
  logic [Q100_W-1:0] q100;
  logic [YEAR_W-1:0] r100;
  logic              leap;
  logic [ACC_W-1:0]  acc_s2;

  assign q100 = prod1[DIV100_SHIFT +: Q100_W];
  assign r100 = z1 - YEAR_W'(q100) * YEAR_W'(100);
  // Leap rule is needed only in February, where z is the year minus one.
  assign leap = (z1[1:0] == 2'd3) &&
                ((r100 != YEAR_W'(99)) || (q100[1:0] == 2'd3));
  assign acc_s2 = base1 + ACC_W'(z1 >> 2) + ACC_W'(q100 >> 2) - ACC_W'(q100);

  logic               ok2;
  logic [MODE_W-1:0]  mode2;
  logic [WDAY_W-1:0]  wday2;
  logic [DAY_W-1:0]   dim2;
  logic [ACC_W-1:0]   acc2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      ok2   <= ok1;
      mode2 <= mode1;
      wday2 <= wday1;
      dim2  <= month_days(month1, leap);
      acc2  <= acc_s2;
    end
  end

  // Stage 3: weekday of the first of the month.
  logic               ok3;
  logic [MODE_W-1:0]  mode3;
  logic [WDAY_W-1:0]  wday3;
  logic [DAY_W-1:0]   dim3;
  logic [2:0]         first3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      ok3    <= ok2;
      mode3  <= mode2;
      wday3  <= wday2;
      dim3   <= dim2;
      first3 <= mod7(acc2);
    end
  end

  // Stage 4: pick the requested occurrence.
  logic [3:0]       diff;
  logic [3:0]       off;
  logic [5:0]       d1;
  logic [5:0]       cand;
  logic [DAY_W-1:0] day;

  assign diff = 4'(wday3) - 4'(first3);
  assign off  = diff[3] ? diff + 4'd7 : diff;
  assign d1   = 6'(off) + 6'd1;

  always_comb begin
    cand = d1;
    day  = '0;
    if (ok3) begin
      if (mode3 inside {[3'd0:MODE_FIFTH]}) begin
        cand = d1 + 6'(mode3) * 6'd7;
        day  = (cand <= 6'(dim3)) ? cand[DAY_W-1:0] : '0;
      end else if (mode3 == MODE_LAST) begin
        cand = d1 + 6'd28;
        day  = (cand <= 6'(dim3)) ? cand[DAY_W-1:0] : DAY_W'(d1 + 6'd21);
      end else begin
        // The teenth week starts on the 13th.
        cand = (d1 >= 6'd6) ? d1 + 6'd7 : d1 + 6'd14;
        day  = cand[DAY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en4) begin
      m_tvalid <= v3;
    end
    if (en4) begin
      m_tdata <= OUT_DATA_W'(day);
    end
  end

endmodule

`default_nettype wire

// ===== tb/meetup_checker.sv =====
`timescale 1ns / 100ps

module meetup_checker
  import nwom_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  // year [13:0], month [17:14], mode [20:18], weekday [23:21]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  // meet_day [4:0], zero fill above
  input  wire logic [OUT_DATA_W-1:0] m_tdata,
  output int                         fail_count,
  output int                         pending
);

  localparam int MONTH_LSB = YEAR_W;
  localparam int MODE_LSB  = MONTH_LSB + MONTH_W;
  localparam int WDAY_LSB  = MODE_LSB + MODE_W;

  logic [DAY_W-1:0] expected_days[$];

  // Day of the month for the selected occurrence of a weekday, 0 when none or the query is invalid.
  function automatic logic [DAY_W-1:0] meetup_day(input logic [YEAR_W-1:0]  yr,
                                                  input logic [MONTH_W-1:0] mon,
                                                  input logic [MODE_W-1:0]  sel,
                                                  input logic [WDAY_W-1:0]  wd);
    int unsigned y;
    int unsigned m;
    int unsigned z;
    int unsigned acc;
    int unsigned first;
    int unsigned dim;
    int unsigned d;
    bit          leap;
    y = 32'(yr);
    m = 32'(mon);
    if (yr < 1 || yr > YEAR_MAX || mon < MONTH_JAN || mon > MONTH_DEC ||
        wd > WDAY_SAT || sel > MODE_TEENTH)
      return '0;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (mon)
      MONTH_FEB:               dim = leap ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: dim = 30;
      default:                 dim = 31;
    endcase
    // January and February count as months of the previous year here.
    if (mon < MONTH_MAR) begin
      acc = 1 + y;
      z = y - 1;
    end else begin
      acc = y - 1;
      z = y;
    end
    acc = acc + (23 * m) / 9 + 4 + z / 4 + z / 400 - z / 100;
    first = acc % 7;
    d = ((wd + 7 - first) % 7) + 1;
    if (sel <= MODE_FIFTH) begin
      d = d + 7 * sel;
      if (d > dim) d = 0;
    end else if (sel == MODE_LAST) begin
      while (d + 7 <= dim) d = d + 7;
    end else begin
      while (d < 13) d = d + 7;
      if (d > 19) d = 0;
    end
    return DAY_W'(d);
  endfunction

  always @(posedge clk) begin
    logic [DAY_W-1:0] want;
    if (rst) begin
      expected_days.delete();
      pending = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_days.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: unexpected item, expected none, got meet_day %0d",
                   $time, m_tdata[DAY_W-1:0]);
        end else begin
          want = expected_days.pop_front();
          if (m_tdata !== OUT_DATA_W'(want)) begin
            fail_count = fail_count + 1;
            $display("%0t: meet_day expected %0d, got %0d (tdata 0x%02h)",
                     $time, want, m_tdata[DAY_W-1:0], m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_days.push_back(meetup_day(s_tdata[YEAR_W-1:0],
                                           s_tdata[MONTH_LSB +: MONTH_W],
                                           s_tdata[MODE_LSB +: MODE_W],
                                           s_tdata[WDAY_LSB +: WDAY_W]));
      pending = expected_days.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench
  import nwom_pkg::*;
;

  localparam logic [MODE_W-1:0] SEL_FIRST  = 3'd0;
  localparam logic [MODE_W-1:0] SEL_SECOND = 3'd1;
  localparam logic [MODE_W-1:0] SEL_THIRD  = 3'd2;
  localparam logic [MODE_W-1:0] SEL_FOURTH = 3'd3;
  localparam logic [MODE_W-1:0] SEL_BAD    = 3'd7;

  localparam logic [WDAY_W-1:0] WD_SUN = 3'd0;
  localparam logic [WDAY_W-1:0] WD_MON = 3'd1;
  localparam logic [WDAY_W-1:0] WD_TUE = 3'd2;
  localparam logic [WDAY_W-1:0] WD_WED = 3'd3;
  localparam logic [WDAY_W-1:0] WD_THU = 3'd4;
  localparam logic [WDAY_W-1:0] WD_FRI = 3'd5;
  localparam logic [WDAY_W-1:0] WD_BAD = 3'd7;

  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_EVERY  = 250;
  localparam int STALL_LIMIT  = 2000;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    fail_count;
  int                    pending;

  int burst_left = 0;
  int rx_style = 0;
  int rx_left = 0;
  int rx_hold = 0;

  nth_weekday_of_month u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  meetup_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The receiver switches at random among four manners of driving m_tready.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold != 0) begin
          rx_hold <= rx_hold - 1;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(1, 30);
        end
      end
    endcase
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offers one query and returns at the edge where it is accepted.
  task automatic send_query(input logic [YEAR_W-1:0]  yr,
                            input logic [MONTH_W-1:0] mon,
                            input logic [MODE_W-1:0]  sel,
                            input logic [WDAY_W-1:0]  wd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {wd, sel, mon, yr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left = burst_left - 1;
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [YEAR_W-1:0]  yr;
    logic [MONTH_W-1:0] mon;
    logic [MODE_W-1:0]  sel;
    logic [WDAY_W-1:0]  wd;
    int                 pick;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_query(14'd1, 4'd1, SEL_FIRST, WD_SUN);
    send_query(14'd9999, 4'd12, MODE_LAST, WDAY_SAT);
    send_query(14'd9999, 4'd12, MODE_FIFTH, WD_FRI);
    // A fifth Monday in a 28-day February that starts on a Monday.
    send_query(14'd2021, 4'd2, MODE_FIFTH, WD_MON);
    send_query(14'd2024, 4'd2, MODE_FIFTH, WD_THU);
    send_query(14'd2000, 4'd2, MODE_LAST, WD_TUE);
    send_query(14'd1900, 4'd2, MODE_LAST, WD_WED);
    send_query(14'd2100, 4'd2, MODE_TEENTH, WD_SUN);
    send_query(14'd2013, 4'd5, MODE_TEENTH, WD_MON);
    send_query(14'd2013, 4'd8, SEL_SECOND, WD_WED);
    send_query(14'd2013, 4'd9, SEL_THIRD, WD_THU);
    send_query(14'd2013, 4'd10, SEL_FOURTH, WD_FRI);
    send_query(14'd2013, 4'd11, SEL_FIRST, WDAY_SAT);
    send_query(14'd0, 4'd6, SEL_FIRST, WD_MON);
    send_query(14'd10000, 4'd6, SEL_FIRST, WD_MON);
    send_query(14'd16383, 4'd15, SEL_BAD, WD_BAD);
    send_query(14'd2015, 4'd0, SEL_FIRST, WD_TUE);
    send_query(14'd2015, 4'd13, MODE_LAST, WD_TUE);
    send_query(14'd2015, 4'd15, MODE_LAST, WD_TUE);
    send_query(14'd2015, 4'd7, SEL_BAD, WD_TUE);
    send_query(14'd2015, 4'd7, SEL_FIRST, WD_BAD);
    send_query(14'd8191, 4'd12, MODE_TEENTH, WDAY_SAT);
    send_query(14'd4000, 4'd3, MODE_LAST, WD_WED);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      yr = YEAR_W'($urandom_range(1, 9999));
      mon = MONTH_W'($urandom_range(1, 12));
      sel = MODE_W'($urandom_range(0, 6));
      wd = WDAY_W'($urandom_range(0, 6));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // Years near the ends of the range and around the leap exceptions.
        case ($urandom_range(0, 3))
          0: yr = YEAR_W'($urandom_range(1, 4));
          1: yr = YEAR_W'($urandom_range(9996, 9999));
          2: yr = YEAR_W'(100 * $urandom_range(1, 99));
          default: yr = YEAR_W'(400 * $urandom_range(1, 24));
        endcase
      end else if (pick < 22) begin
        case ($urandom_range(0, 5))
          0: yr = YEAR_W'($urandom_range(10000, 16383));
          1: yr = '0;
          2: mon = MONTH_W'($urandom_range(0, 15));
          3: sel = SEL_BAD;
          4: wd = WD_BAD;
          default: {wd, sel, mon, yr} = IN_DATA_W'($urandom());
        endcase
      end
      send_query(yr, mon, sel, wd);
      if ((i + 1) % DRAIN_EVERY == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/nwom_pkg.sv
design/nth_weekday_of_month.sv
tb/meetup_checker.sv
tb/testbench.sv
